// ----- hw/rtl/sdda_pkg.sv -----
// Shared types and constants for the DDA stepper axis.
// No dependencies; the top level refers to these by scoped names.
package sdda_pkg;

    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int POS_W       = 32;
    localparam int SPU_W       = 16;
    localparam int INTERVAL_W  = 31;
    localparam int ACC_W       = 40;
    localparam int DELTA_W     = 33;
    localparam int PROD_W      = POS_W + SPU_W;

    localparam logic [POS_W-1:0] HOME_BACKOFF = 32'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_UNIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTICAL_ENDSTOP = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_RESET_AXIS = 2'd2,
        CMD_HOME_TICK  = 2'd3
    } cmd_t;

endpackage

// ----- hw/rtl/stepper_axis_dda.sv -----
// Top level of the DDA stepper axis: scale stage, axis state and result beat.
// Depends on sdda_pkg.
//
// One stepper axis with a Bresenham accumulator. Each input beat (tick, set
// target, reset axis, homing tick) yields exactly one result beat, held in
// the scale-stage registers and then in the result registers; a new beat is
// accepted every cycle while the output is not stalled. The first stage
// scales the Q-format target by steps_per_unit (one 32x16 multiply); the
// second stage updates the accumulator, step distance and position, and its
// update loop sets the rate of one beat per cycle. While a result waits on
// out_ready the first stage takes at most one more beat and then holds
// in_ready low. Configuration registers are written through cfg_write/
// cfg_index/cfg_data and take effect for beats accepted afterwards; write
// them only while the axis is idle. There is no startup pass after reset.
module stepper_axis_dda #(
    parameter int POSITION_FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [sdda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdda_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sdda_pkg::CMD_W-1:0]          command,
    input  logic signed [sdda_pkg::POS_W-1:0]   target_position,
    input  logic [sdda_pkg::INTERVAL_W-1:0]     interval_count,
    input  logic                                endstop_level,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                step_pulse,
    output logic                                dir_level,
    output logic                                enable_n,
    output logic signed [sdda_pkg::POS_W-1:0]   position,
    output logic                                homed
);

    localparam int POS_W   = sdda_pkg::POS_W;
    localparam int ACC_W   = sdda_pkg::ACC_W;
    localparam int DELTA_W = sdda_pkg::DELTA_W;
    localparam int PROD_W  = sdda_pkg::PROD_W;
    localparam int IVL_W   = sdda_pkg::INTERVAL_W;

    localparam logic [PROD_W-1:0] SAT_NEG_MAG = PROD_W'(64'h8000_0000);
    localparam logic [PROD_W-1:0] SAT_POS_MAG = PROD_W'(64'h7FFF_FFFF);

    // configuration
    logic [sdda_pkg::SPU_W-1:0] steps_per_unit_reg;
    logic signed [POS_W-1:0]    min_limit_reg;
    logic signed [POS_W-1:0]    max_limit_reg;
    logic                       optical_endstop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_per_unit_reg  <= '0;
            min_limit_reg       <= '0;
            max_limit_reg       <= '0;
            optical_endstop_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sdda_pkg::CFG_STEPS_PER_UNIT:
                    steps_per_unit_reg <= cfg_data[sdda_pkg::SPU_W-1:0];
                sdda_pkg::CFG_MIN_LIMIT:
                    min_limit_reg <= cfg_data[POS_W-1:0];
                sdda_pkg::CFG_MAX_LIMIT:
                    max_limit_reg <= cfg_data[POS_W-1:0];
                sdda_pkg::CFG_OPTICAL_ENDSTOP:
                    optical_endstop_reg <= cfg_data[0];
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s2_load;
    logic fire;

    assign s2_load   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s2_load;
    assign fire      = s1_valid_reg && s2_load;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1: scale target magnitude
    logic [POS_W-1:0]   tpos_mag;
    logic [PROD_W-1:0]  scaled_next;

    sdda_pkg::cmd_t     s1_cmd_reg;
    logic               s1_neg_reg;
    logic [PROD_W-1:0]  s1_scaled_reg;
    logic [IVL_W-1:0]   s1_interval_reg;
    logic               s1_level_reg;

    always_comb
    begin
        tpos_mag    = target_position[POS_W-1] ? (POS_W'(0) - target_position)
                                               : target_position;
        scaled_next = ({{(PROD_W-POS_W){1'b0}}, tpos_mag}
                       * {{(PROD_W-sdda_pkg::SPU_W){1'b0}}, steps_per_unit_reg})
                      >> POSITION_FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_cmd_reg      <= sdda_pkg::CMD_TICK;
            s1_neg_reg      <= 1'b0;
            s1_scaled_reg   <= '0;
            s1_interval_reg <= '0;
            s1_level_reg    <= 1'b0;
        end
        else if (in_ready && in_valid)
        begin
            s1_cmd_reg      <= sdda_pkg::cmd_t'(command);
            s1_neg_reg      <= target_position[POS_W-1];
            s1_scaled_reg   <= scaled_next;
            s1_interval_reg <= interval_count;
            s1_level_reg    <= endstop_level;
        end
    end

    // stage 2: axis state
    logic [ACC_W-1:0]        acc_reg,      acc_next;
    logic [DELTA_W-1:0]      delta_reg,    delta_next;
    logic                    fwd_reg,      fwd_next;
    logic signed [POS_W-1:0] pos_reg,      pos_next;
    logic                    dir_reg,      dir_next;
    logic                    en_reg,       en_next;
    logic                    pulse_reg,    pulse_next;
    logic                    homed_reg,    homed_next;

    logic [POS_W-1:0]   target_steps;
    logic [DELTA_W-1:0] diff_fwd;
    logic [DELTA_W-1:0] diff_bwd;
    logic [ACC_W-1:0]   acc_sum;
    logic [ACC_W-1:0]   acc_sub;
    logic               max_ok;
    logic               min_ok;
    logic               reached;

    always_comb
    begin
        if (s1_neg_reg)
            target_steps = (s1_scaled_reg > SAT_NEG_MAG) ? SAT_NEG_MAG[POS_W-1:0]
                                                         : POS_W'(0) - s1_scaled_reg[POS_W-1:0];
        else
            target_steps = (s1_scaled_reg > SAT_POS_MAG) ? SAT_POS_MAG[POS_W-1:0]
                                                         : s1_scaled_reg[POS_W-1:0];

        diff_fwd = {target_steps[POS_W-1], target_steps} - {pos_reg[POS_W-1], pos_reg};
        diff_bwd = {pos_reg[POS_W-1], pos_reg} - {target_steps[POS_W-1], target_steps};

        acc_sum = acc_reg + {{(ACC_W-DELTA_W){1'b0}}, delta_reg};
        acc_sub = acc_reg + {{(ACC_W-DELTA_W){1'b0}}, delta_reg}
                  - {{(ACC_W-IVL_W){1'b0}}, s1_interval_reg};

        max_ok  = (max_limit_reg == '0) || (pos_reg <= max_limit_reg);
        min_ok  = (min_limit_reg == '0) || (pos_reg >= min_limit_reg);
        reached = optical_endstop_reg ? s1_level_reg : !s1_level_reg;

        acc_next   = acc_reg;
        delta_next = delta_reg;
        fwd_next   = fwd_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        en_next    = en_reg;
        pulse_next = 1'b0;
        homed_next = 1'b0;

        unique case (s1_cmd_reg)
            sdda_pkg::CMD_TICK:
            begin
                acc_next = acc_sum;
                if (!acc_sum[ACC_W-1])
                begin
                    acc_next = acc_sub;
                    dir_next = fwd_reg;
                    if (fwd_reg && max_ok)
                    begin
                        pulse_next = 1'b1;
                        pos_next   = pos_reg + POS_W'(1);
                    end
                    else if (!fwd_reg && min_ok)
                    begin
                        pulse_next = 1'b1;
                        pos_next   = pos_reg - POS_W'(1);
                    end
                end
            end
            sdda_pkg::CMD_SET_TARGET:
            begin
                fwd_next   = !diff_fwd[DELTA_W-1];
                delta_next = diff_fwd[DELTA_W-1] ? diff_bwd : diff_fwd;
                if (diff_fwd != '0)
                    en_next = 1'b1;
            end
            sdda_pkg::CMD_RESET_AXIS:
            begin
                en_next    = 1'b0;
                pos_next   = '0;
                delta_next = '0;
            end
            sdda_pkg::CMD_HOME_TICK:
            begin
                en_next  = 1'b1;
                dir_next = 1'b0;
                if (reached)
                begin
                    pos_next   = min_limit_reg - sdda_pkg::HOME_BACKOFF;
                    homed_next = 1'b1;
                end
                else
                begin
                    pulse_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            delta_reg <= '0;
            fwd_reg   <= 1'b1;
            pos_reg   <= '0;
            dir_reg   <= 1'b0;
            en_reg    <= 1'b0;
        end
        else if (fire)
        begin
            acc_reg   <= acc_next;
            delta_reg <= delta_next;
            fwd_reg   <= fwd_next;
            pos_reg   <= pos_next;
            dir_reg   <= dir_next;
            en_reg    <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pulse_reg <= pulse_next;
            homed_reg <= homed_next;
        end
    end

    // state changes only when a new result loads, so the pins read it directly
    assign step_pulse = pulse_reg;
    assign homed      = homed_reg;
    assign dir_level  = dir_reg;
    assign enable_n   = !en_reg;
    assign position   = pos_reg;

    // checks
    a_homed_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && homed_reg |-> !pulse_reg)
        else $error("homing result carries a step pulse");

    a_homed_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && homed_reg |-> en_reg && !dir_reg)
        else $error("homing result without driver enabled and direction low");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pos_reg) && $stable(acc_reg) && $stable(delta_reg))
        else $error("axis state changed without a result load");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_load |=> s1_valid_reg && $stable(s1_scaled_reg))
        else $error("scale stage dropped a stalled beat");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for stepper_axis_dda: a directed table, then random moves,
// homing runs, axis resets and noise, scored against a behavioral axis model
// or typed expectations. Depends on sdda_pkg and the stepper_axis_dda RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 8;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASE_BEATS = 240;
    localparam int NUM_SETS    = 9;

    typedef struct packed {
        sdda_pkg::cmd_t cmd;
        logic [31:0]    tpos;
        logic [30:0]    intv;
        logic           lvl;
    } axis_beat_t;

    typedef struct packed {
        logic        pulse;
        logic        dir;
        logic        en_n;
        logic [31:0] pos;
        logic        homed;
    } axis_status_t;

    typedef struct packed {
        logic [15:0] spu;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        opt;
    } axis_cfg_t;

    // cfg_sel of zero keeps the current registers
    typedef struct packed {
        logic [3:0]   cfg_sel;
        logic         typed;
        axis_beat_t   beat;
        axis_status_t want;
    } dir_row_t;

    logic                            clk             = 1'b0;
    logic                            rst_n           = 1'b0;
    logic                            cfg_write       = 1'b0;
    logic [sdda_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [sdda_pkg::CFG_DATA_W-1:0] cfg_data        = '0;
    logic                            in_valid        = 1'b0;
    logic                            in_ready;
    logic [sdda_pkg::CMD_W-1:0]      command         = sdda_pkg::CMD_TICK;
    logic signed [31:0]              target_position = '0;
    logic [30:0]                     interval_count  = '0;
    logic                            endstop_level   = 1'b0;
    logic                            out_valid;
    logic                            out_ready       = 1'b0;
    logic                            step_pulse;
    logic                            dir_level;
    logic                            enable_n;
    logic signed [31:0]              position;
    logic                            homed;

    // axis model state and register copies
    logic [39:0]        ax_acc   = '0;
    logic [32:0]        ax_delta = '0;
    logic               ax_fwd   = 1'b1;
    logic [31:0]        ax_pos   = '0;
    logic [31:0]        ax_tgt   = '0;
    logic               ax_dir   = 1'b0;
    logic               ax_en    = 1'b0;
    logic [15:0]        cfg_spu  = '0;
    logic signed [31:0] cfg_lo   = '0;
    logic signed [31:0] cfg_hi   = '0;
    logic               cfg_opt  = 1'b0;

    axis_status_t awaited_status[$];
    dir_row_t     directed_rows[$];
    axis_cfg_t    cfg_sets[NUM_SETS];

    int beats_sent    = 0;
    int status_seen   = 0;
    int steps_seen    = 0;
    int homes_seen    = 0;
    int mismatches    = 0;
    int settings_used = 0;
    int hold_len      = 0;
    bit calm          = 1'b0;

    stepper_axis_dda #(
        .POSITION_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .target_position(target_position),
        .interval_count(interval_count),
        .endstop_level(endstop_level),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .step_pulse(step_pulse),
        .dir_level(dir_level),
        .enable_n(enable_n),
        .position(position),
        .homed(homed)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] scale_to_steps(input logic [31:0] raw);
        logic        neg;
        logic [32:0] mag;
        logic [63:0] prod;
        neg  = raw[31];
        mag  = neg ? 33'd0 - {raw[31], raw} : {1'b0, raw};
        prod = ({31'd0, mag} * {48'd0, cfg_spu}) >> FRAC_BITS;
        if (neg)
        begin
            if (prod > 64'h8000_0000)
                prod = 64'h8000_0000;
            return 32'd0 - prod[31:0];
        end
        if (prod > 64'h7FFF_FFFF)
            prod = 64'h7FFF_FFFF;
        return prod[31:0];
    endfunction

    function automatic axis_status_t advance_axis(input axis_beat_t b);
        axis_status_t       st;
        logic signed [33:0] diff;
        logic               reached;
        st = '0;
        unique case (b.cmd)
            sdda_pkg::CMD_TICK:
            begin
                ax_acc = ax_acc + {7'd0, ax_delta};
                if (!ax_acc[39])
                begin
                    ax_dir = ax_fwd;
                    ax_acc = ax_acc - {9'd0, b.intv};
                    if (ax_fwd)
                    begin
                        if (cfg_hi == 0 || $signed(ax_pos) <= cfg_hi)
                        begin
                            st.pulse = 1'b1;
                            ax_pos   = ax_pos + 32'd1;
                        end
                    end
                    else if (cfg_lo == 0 || $signed(ax_pos) >= cfg_lo)
                    begin
                        st.pulse = 1'b1;
                        ax_pos   = ax_pos - 32'd1;
                    end
                end
            end
            sdda_pkg::CMD_SET_TARGET:
            begin
                ax_tgt = scale_to_steps(b.tpos);
                diff   = $signed({ax_tgt[31], ax_tgt[31], ax_tgt})
                         - $signed({ax_pos[31], ax_pos[31], ax_pos});
                ax_fwd = 1'b1;
                if (diff != 0)
                    ax_en = 1'b1;
                if (diff < 0)
                begin
                    diff   = -diff;
                    ax_fwd = 1'b0;
                end
                ax_delta = diff[32:0];
            end
            sdda_pkg::CMD_RESET_AXIS:
            begin
                ax_en    = 1'b0;
                ax_pos   = '0;
                ax_tgt   = '0;
                ax_delta = '0;
            end
            sdda_pkg::CMD_HOME_TICK:
            begin
                reached = cfg_opt ? b.lvl : !b.lvl;
                ax_en   = 1'b1;
                ax_dir  = 1'b0;
                if (reached)
                begin
                    ax_pos   = cfg_lo - sdda_pkg::HOME_BACKOFF;
                    st.homed = 1'b1;
                end
                else
                    st.pulse = 1'b1;
            end
        endcase
        st.dir  = ax_dir;
        st.en_n = !ax_en;
        st.pos  = ax_pos;
        return st;
    endfunction

    function automatic void add_row(input logic [3:0] sel, input sdda_pkg::cmd_t cmd,
                                    input logic [31:0] tpos, input logic [30:0] intv,
                                    input logic lvl, input logic typed,
                                    input axis_status_t want);
        dir_row_t r;
        r.cfg_sel = sel;
        r.typed   = typed;
        r.beat    = {cmd, tpos, intv, lvl};
        r.want    = want;
        directed_rows.push_back(r);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < MAX_SHOWN)
                $display("mismatch on status beat %0d: %s expected %0h, got %0h",
                         status_seen, name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_beat(input axis_beat_t b, input logic typed,
                             input axis_status_t want);
        axis_status_t got;
        while (!calm && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= b.cmd;
        target_position <= b.tpos;
        interval_count  <= b.intv;
        endstop_level   <= b.lvl;
        do
            @(posedge clk);
        while (!in_ready);
        got = advance_axis(b);
        awaited_status.push_back(typed ? want : got);
        beats_sent++;
    endtask

    task automatic drain_axis();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_cfg(input axis_cfg_t c);
        cfg_write <= 1'b1;
        cfg_index <= sdda_pkg::CFG_STEPS_PER_UNIT;
        cfg_data  <= {16'd0, c.spu};
        @(posedge clk);
        cfg_index <= sdda_pkg::CFG_MIN_LIMIT;
        cfg_data  <= c.lo;
        @(posedge clk);
        cfg_index <= sdda_pkg::CFG_MAX_LIMIT;
        cfg_data  <= c.hi;
        @(posedge clk);
        cfg_index <= sdda_pkg::CFG_OPTICAL_ENDSTOP;
        cfg_data  <= {31'd0, c.opt};
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_spu   = c.spu;
        cfg_lo    = c.lo;
        cfg_hi    = c.hi;
        cfg_opt   = c.opt;
        settings_used++;
    endtask

    task automatic random_traffic(input int quota);
        int          stop;
        int          n;
        int          pick;
        axis_beat_t  b;
        logic [33:0] iv;
        stop = beats_sent + quota;
        while (beats_sent < stop)
        begin
            pick   = $urandom_range(0, 99);
            b.tpos = $urandom;
            b.intv = 31'($urandom);
            b.lvl  = 1'($urandom);
            if (pick < 55)
            begin
                b.cmd = sdda_pkg::CMD_SET_TARGET;
                if ($urandom_range(0, 4) != 0)
                    b.tpos = $urandom_range(0, 32768) - 16384;
                push_beat(b, 1'b0, '0);
                n = $urandom_range(1, 40);
                repeat (n)
                begin
                    b.cmd  = sdda_pkg::CMD_TICK;
                    b.tpos = $urandom;
                    b.lvl  = 1'($urandom);
                    pick   = $urandom_range(0, 19);
                    iv     = {1'b0, ax_delta} + ({1'b0, ax_delta} >> $urandom_range(0, 3));
                    if (pick == 0)
                        iv = '0;
                    else if (pick < 4)
                        iv = 34'($urandom & 32'h7FFF_FFFF);
                    else if (pick < 7)
                        iv = 34'($urandom_range(1, 64));
                    if (iv > 34'h7FFF_FFFF)
                        iv = 34'h7FFF_FFFF;
                    b.intv = iv[30:0];
                    push_beat(b, 1'b0, '0);
                end
            end
            else if (pick < 72)
            begin
                b.cmd = sdda_pkg::CMD_HOME_TICK;
                n     = $urandom_range(0, 12);
                repeat (n)
                begin
                    b.lvl  = !cfg_opt;
                    b.tpos = $urandom;
                    push_beat(b, 1'b0, '0);
                end
                b.lvl = cfg_opt;
                push_beat(b, 1'b0, '0);
            end
            else if (pick < 77)
            begin
                b.cmd = sdda_pkg::CMD_RESET_AXIS;
                push_beat(b, 1'b0, '0);
            end
            else
            begin
                b.cmd = sdda_pkg::cmd_t'($urandom_range(0, 3));
                push_beat(b, 1'b0, '0);
            end
        end
    endtask

    initial
    begin : status_sink
        axis_status_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (awaited_status.size() == 0)
                begin
                    if (mismatches < MAX_SHOWN)
                        $display("status beat %0d arrived with nothing pending, position %0h",
                                 status_seen, position);
                    mismatches++;
                end
                else
                begin
                    want = awaited_status.pop_front();
                    check_field("step_pulse", 32'(want.pulse), 32'(step_pulse));
                    check_field("dir_level", 32'(want.dir), 32'(dir_level));
                    check_field("enable_n", 32'(want.en_n), 32'(enable_n));
                    check_field("position", want.pos, position);
                    check_field("homed", 32'(want.homed), 32'(homed));
                end
                status_seen++;
                steps_seen += int'(step_pulse);
                homes_seen += int'(homed);
            end
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                hold_len--;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("run timed out with %0d status beats pending", awaited_status.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t row;
        cfg_sets[0] = {16'd0, 32'd0, 32'd0, 1'b0};
        cfg_sets[1] = {16'd65535, -32'sd100, 32'sd100, 1'b1};
        cfg_sets[2] = {16'd256, 32'h8000_000F, 32'd0, 1'b1};
        cfg_sets[3] = {16'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0};
        cfg_sets[4] = {16'd300, -32'sd40, 32'sd40, 1'b0};
        cfg_sets[5] = {16'd65535, 32'd0, 32'd0, 1'b1};
        cfg_sets[6] = {16'd0, -32'sd5, 32'sd5, 1'b0};
        cfg_sets[7] = {16'($urandom_range(1, 2000)), 32'd0 - $urandom_range(1, 500),
                       32'($urandom_range(1, 500)), 1'($urandom)};
        cfg_sets[8] = {16'd256, 32'h8000_0000, 32'h7FFF_FFF0, 1'b0};

        // power-up registers, expectations read straight off the axis behavior
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd5, 1'b0, 1'b1,
                {1'b1, 1'b1, 1'b1, 32'd1, 1'b0});
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd5, 1'b0, 1'b1,
                {1'b0, 1'b1, 1'b1, 32'd1, 1'b0});
        add_row(0, sdda_pkg::CMD_RESET_AXIS, 32'd0, 31'd5, 1'b0, 1'b1,
                {1'b0, 1'b1, 1'b1, 32'd0, 1'b0});
        add_row(0, sdda_pkg::CMD_HOME_TICK, 32'h7FFF_FFFF, 31'd0, 1'b1, 1'b1,
                {1'b1, 1'b0, 1'b0, 32'd0, 1'b0});
        add_row(0, sdda_pkg::CMD_HOME_TICK, 32'h7FFF_FFFF, 31'd0, 1'b0, 1'b1,
                {1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b1});
        add_row(0, sdda_pkg::CMD_RESET_AXIS, 32'd0, 31'd0, 1'b0, 1'b1,
                {1'b0, 1'b0, 1'b1, 32'd0, 1'b0});
        add_row(0, sdda_pkg::CMD_SET_TARGET, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1, 1'b1,
                {1'b0, 1'b0, 1'b1, 32'd0, 1'b0});
        // saturating targets, soft limits, optical endstop
        add_row(1, sdda_pkg::CMD_SET_TARGET, 32'h7FFF_FFFF, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'h7FFF_FFFF, 1'b1, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b1, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_HOME_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_HOME_TICK, 32'd0, 31'd0, 1'b1, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_SET_TARGET, 32'h8000_0000, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_SET_TARGET, 32'h0000_0100, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        // home near the top of the range, full-span delta, position wrap
        add_row(2, sdda_pkg::CMD_HOME_TICK, 32'd0, 31'd0, 1'b1, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_SET_TARGET, 32'h8000_0000, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_SET_TARGET, 32'h7FFF_FFFF, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);
        add_row(0, sdda_pkg::CMD_TICK, 32'd0, 31'd0, 1'b0, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.cfg_sel != 0)
            begin
                drain_axis();
                load_cfg(cfg_sets[row.cfg_sel]);
            end
            push_beat(row.beat, row.typed, row.want);
        end

        for (int p = 3; p < NUM_SETS; p++)
        begin
            drain_axis();
            load_cfg(cfg_sets[p]);
            calm = (p == 5);
            if (p == 4)
            begin
                random_traffic(PHASE_BEATS / 2);
                // hold the result side while beats keep coming
                calm     = 1'b1;
                hold_len = 400;
                random_traffic(60);
                calm     = 1'b0;
                random_traffic(PHASE_BEATS / 2);
            end
            else if (p == 6)
            begin
                random_traffic(PHASE_BEATS / 2);
                drain_axis();
                random_traffic(PHASE_BEATS / 2);
            end
            else
                random_traffic(PHASE_BEATS);
        end
        calm = 1'b0;

        drain_axis();
        repeat (8) @(posedge clk);

        $display("%0d command beats under %0d register settings, %0d status beats compared",
                 beats_sent, settings_used, status_seen);
        $display("%0d step pulses and %0d homing hits seen, %0d mismatches",
                 steps_seen, homes_seen, mismatches);
        if (mismatches == 0 && awaited_status.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sdda_pkg.sv
hw/rtl/stepper_axis_dda.sv
tb/tb_top.sv
